// ===== rtl/core/blms_pkg.sv =====
// Shared types, widths and constants for the button and LED mode sequencer.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package blms_pkg;

  // sizing of the event queue and the LED bank
  localparam int FIFO_DEPTH = 10;
  localparam int LED_COUNT  = 4;

  localparam int HEAD_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int POS_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int LED_W  = LED_COUNT;

  // field widths of the channels
  localparam int ACTION_W   = 2;
  localparam int BUTTON_W   = 2;
  localparam int MODE_W     = 2;
  localparam int LEVEL_W    = 16;
  localparam int STEP_W     = 16;
  localparam int DEBOUNCE_W = 10;
  localparam int FADE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MODE_COUNT = 4;

  // configuration reset values
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(50);
  localparam logic [STEP_W-1:0]     DELAY0_RST   = STEP_W'(200);
  localparam logic [STEP_W-1:0]     DELAY1_RST   = STEP_W'(500);
  localparam logic [STEP_W-1:0]     DELAY2_RST   = STEP_W'(100);
  localparam logic [STEP_W-1:0]     DELAY3_RST   = STEP_W'(500);

  localparam logic [DEBOUNCE_W-1:0] SINCE_MAX = '1;
  localparam logic [FADE_W-1:0]     FADE_MAX  = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY3   = 3'd4;

  // button codes
  localparam logic [BUTTON_W-1:0] BTN_1 = 2'd0;
  localparam logic [BUTTON_W-1:0] BTN_2 = 2'd1;
  localparam logic [BUTTON_W-1:0] BTN_3 = 2'd2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK    = 2'd0,
    ACT_PRESS   = 2'd1,
    ACT_PWM_CLK = 2'd2,
    ACT_NOP     = 2'd3
  } action_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_UP    = 2'd0,
    MODE_BLINK = 2'd1,
    MODE_DOWN  = 2'd2,
    MODE_FADE  = 2'd3
  } mode_t;

  // mode transition table, indexed by current mode and button event
  function automatic mode_t next_mode(input mode_t cur, input logic [BUTTON_W-1:0] evt);
    mode_t res;
    res = cur;
    case (cur)
      MODE_UP: begin
        case (evt)
          BTN_2:   res = MODE_BLINK;
          BTN_3:   res = MODE_FADE;
          default: res = MODE_DOWN;
        endcase
      end
      MODE_BLINK: begin
        case (evt)
          BTN_2:   res = MODE_DOWN;
          BTN_3:   res = MODE_FADE;
          default: res = MODE_UP;
        endcase
      end
      MODE_DOWN: begin
        case (evt)
          BTN_2:   res = MODE_UP;
          BTN_3:   res = MODE_FADE;
          default: res = MODE_BLINK;
        endcase
      end
      default: res = MODE_UP;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/blms_if.sv =====
// Valid/ready channel interfaces: input events, results and configuration writes.
// Depends on blms_pkg for field widths.
`timescale 1ns / 1ps

interface blms_in_if;
  logic                          valid;
  logic                          ready;
  logic [blms_pkg::ACTION_W-1:0] action;
  logic [blms_pkg::BUTTON_W-1:0] button;

  modport source (output valid, action, button, input ready);
  modport sink   (input valid, action, button, output ready);
endinterface

interface blms_out_if;
  logic                         valid;
  logic                         ready;
  logic [blms_pkg::LED_W-1:0]   leds;
  logic [blms_pkg::MODE_W-1:0]  mode;
  logic [blms_pkg::LEVEL_W-1:0] pwm_level;
  logic                         press_dropped;

  modport source (output valid, leds, mode, pwm_level, press_dropped, input ready);
  modport sink   (input valid, leds, mode, pwm_level, press_dropped, output ready);
endinterface

interface blms_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [blms_pkg::CFG_IDX_W-1:0]  index;
  logic [blms_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/button_led_mode_sequencer_unit.sv =====
// The result of a transaction sits in the output register the cycle after it is
// accepted. Throughput: one transaction per cycle unless the output stalls; the state
// update and the 8x8 fade multiply plus PWM compare form the single logic stage.
// Reset: rst_n synchronous, active low; clears mode, timers, queue pointers and
// pattern state and loads the default delays. Queue entries are not cleared.
// Depends on blms_pkg and the channel interfaces in blms_if.sv.
`timescale 1ns / 1ps

module button_led_mode_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  blms_in_if.sink     in_ch,
  blms_out_if.source  out_ch,
  blms_cfg_if.sink    cfg_ch
);

  // configuration registers
  logic [blms_pkg::DEBOUNCE_W-1:0] debounce_r;
  logic [blms_pkg::STEP_W-1:0]     delay_r [blms_pkg::MODE_COUNT];

  // sequencer state
  blms_pkg::mode_t                 mode_r, mode_nxt;
  logic [blms_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [blms_pkg::DEBOUNCE_W-1:0] since_r, since_nxt;
  logic [blms_pkg::BUTTON_W-1:0]   fifo_r [blms_pkg::FIFO_DEPTH];
  logic [blms_pkg::HEAD_W-1:0]     head_r, head_nxt;
  logic [blms_pkg::CNT_W-1:0]      count_r, count_nxt;
  logic [blms_pkg::POS_W-1:0]      up_r, up_nxt;
  logic [blms_pkg::POS_W-1:0]      down_r, down_nxt;
  logic                            blink_r, blink_nxt;
  logic [blms_pkg::LED_W-1:0]      pattern_r, pattern_nxt;
  logic [blms_pkg::FADE_W-1:0]     fade_r, fade_nxt;
  logic                            rising_r, rising_nxt;
  logic [blms_pkg::LEVEL_W-1:0]    pwmcnt_r, pwmcnt_nxt;

  // output register
  logic                            out_valid_r;
  logic [blms_pkg::LED_W-1:0]      leds_r, leds_nxt;
  logic [blms_pkg::MODE_W-1:0]     mode_out_r;
  logic [blms_pkg::LEVEL_W-1:0]    level_r, level_nxt;
  logic                            dropped_r, dropped_nxt;

  // helper signals
  logic                            in_ready;
  logic                            in_acc;
  logic                            cfg_acc;
  blms_pkg::action_t               act;
  blms_pkg::mode_t                 sel_mode;
  logic [blms_pkg::STEP_W-1:0]     step_inc;
  logic [blms_pkg::BUTTON_W-1:0]   head_evt;
  logic                            fifo_wr_en;
  logic [blms_pkg::HEAD_W-1:0]     fifo_wr_idx;
  logic [blms_pkg::SUM_W-1:0]      wr_sum;

  // only the three real buttons count as presses
  function automatic logic button_ok(input logic [blms_pkg::BUTTON_W-1:0] btn);
    return (btn == blms_pkg::BTN_1) || (btn == blms_pkg::BTN_2) || (btn == blms_pkg::BTN_3);
  endfunction

  // handshakes: a new transaction enters whenever the output slot frees up
  assign in_ready     = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ready;
  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid;
  assign act          = blms_pkg::action_t'(in_ch.action);

  // queue head entry and tail slot
  assign head_evt = (fifo_r[head_r] == 2'd3) ? blms_pkg::BTN_1 : fifo_r[head_r];
  assign wr_sum   = blms_pkg::SUM_W'(head_r) + blms_pkg::SUM_W'(count_r);
  assign step_inc = step_r + blms_pkg::STEP_W'(1);

  always_comb begin
    if (wr_sum >= blms_pkg::SUM_W'(blms_pkg::FIFO_DEPTH)) begin
      fifo_wr_idx = blms_pkg::HEAD_W'(wr_sum - blms_pkg::SUM_W'(blms_pkg::FIFO_DEPTH));
    end else begin
      fifo_wr_idx = blms_pkg::HEAD_W'(wr_sum);
    end
  end

  // next state for one transaction
  always_comb begin
    mode_nxt    = mode_r;
    step_nxt    = step_r;
    since_nxt   = since_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    up_nxt      = up_r;
    down_nxt    = down_r;
    blink_nxt   = blink_r;
    pattern_nxt = pattern_r;
    fade_nxt    = fade_r;
    rising_nxt  = rising_r;
    pwmcnt_nxt  = pwmcnt_r;
    dropped_nxt = 1'b0;
    fifo_wr_en  = 1'b0;
    sel_mode    = mode_r;

    case (act)
      blms_pkg::ACT_TICK: begin
        if (since_r != blms_pkg::SINCE_MAX) begin
          since_nxt = since_r + blms_pkg::DEBOUNCE_W'(1);
        end
        step_nxt = step_inc;
        if (!(step_inc < delay_r[mode_r] && step_inc != '0)) begin
          step_nxt = '0;
          // take one button event from the queue
          if (count_r != '0) begin
            sel_mode  = blms_pkg::next_mode(mode_r, head_evt);
            head_nxt  = (head_r == blms_pkg::HEAD_W'(blms_pkg::FIFO_DEPTH - 1)) ? '0 :
                        head_r + blms_pkg::HEAD_W'(1);
            count_nxt = count_r - blms_pkg::CNT_W'(1);
            if (sel_mode != mode_r) begin
              pattern_nxt = '0;
              if (sel_mode == blms_pkg::MODE_FADE) begin
                pwmcnt_nxt = '0;
              end
            end
          end
          mode_nxt = sel_mode;
          // step of the resulting mode
          case (sel_mode)
            blms_pkg::MODE_UP: begin
              pattern_nxt = blms_pkg::LED_W'(1) << up_r;
              up_nxt = (up_r == blms_pkg::POS_W'(blms_pkg::LED_COUNT - 1)) ? '0 :
                       up_r + blms_pkg::POS_W'(1);
            end
            blms_pkg::MODE_BLINK: begin
              pattern_nxt = blink_r ? '1 : '0;
              blink_nxt   = !blink_r;
            end
            blms_pkg::MODE_DOWN: begin
              pattern_nxt = blms_pkg::LED_W'(1) << down_r;
              down_nxt = (down_r == '0) ? blms_pkg::POS_W'(blms_pkg::LED_COUNT - 1) :
                         down_r - blms_pkg::POS_W'(1);
            end
            default: begin
            end
          endcase
        end
      end
      blms_pkg::ACT_PRESS: begin
        if (button_ok(in_ch.button) && since_r > debounce_r) begin
          since_nxt = '0;
          if (count_r >= blms_pkg::CNT_W'(blms_pkg::FIFO_DEPTH)) begin
            dropped_nxt = 1'b1;
          end else begin
            fifo_wr_en = 1'b1;
            count_nxt  = count_r + blms_pkg::CNT_W'(1);
          end
        end
      end
      blms_pkg::ACT_PWM_CLK: begin
        if (mode_r == blms_pkg::MODE_FADE) begin
          pwmcnt_nxt = pwmcnt_r + blms_pkg::LEVEL_W'(1);
          // fade walks one step per counter wrap, holding one wrap at each end
          if (pwmcnt_nxt == '0) begin
            if (rising_r) begin
              if (fade_r == blms_pkg::FADE_MAX) begin
                rising_nxt = 1'b0;
              end else begin
                fade_nxt = fade_r + blms_pkg::FADE_W'(1);
              end
            end else begin
              if (fade_r == '0) begin
                rising_nxt = 1'b1;
              end else begin
                fade_nxt = fade_r - blms_pkg::FADE_W'(1);
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result fields from the updated state
  always_comb begin
    level_nxt = blms_pkg::LEVEL_W'(fade_nxt) * blms_pkg::LEVEL_W'(fade_nxt);
    leds_nxt  = pattern_nxt;
    if (mode_nxt == blms_pkg::MODE_FADE) begin
      leds_nxt[0] = (pwmcnt_nxt < level_nxt);
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= blms_pkg::DEBOUNCE_RST;
      delay_r[0] <= blms_pkg::DELAY0_RST;
      delay_r[1] <= blms_pkg::DELAY1_RST;
      delay_r[2] <= blms_pkg::DELAY2_RST;
      delay_r[3] <= blms_pkg::DELAY3_RST;
    end else if (cfg_acc) begin
      case (cfg_ch.index)
        blms_pkg::REG_DEBOUNCE: debounce_r <= cfg_ch.data[blms_pkg::DEBOUNCE_W-1:0];
        blms_pkg::REG_DELAY0:   delay_r[0] <= cfg_ch.data;
        blms_pkg::REG_DELAY1:   delay_r[1] <= cfg_ch.data;
        blms_pkg::REG_DELAY2:   delay_r[2] <= cfg_ch.data;
        blms_pkg::REG_DELAY3:   delay_r[3] <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= blms_pkg::MODE_UP;
      step_r    <= '0;
      since_r   <= '0;
      head_r    <= '0;
      count_r   <= '0;
      up_r      <= '0;
      down_r    <= blms_pkg::POS_W'(blms_pkg::LED_COUNT - 1);
      blink_r   <= 1'b0;
      pattern_r <= '0;
      fade_r    <= '0;
      rising_r  <= 1'b1;
      pwmcnt_r  <= '0;
    end else if (in_acc) begin
      mode_r    <= mode_nxt;
      step_r    <= step_nxt;
      since_r   <= since_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      up_r      <= up_nxt;
      down_r    <= down_nxt;
      blink_r   <= blink_nxt;
      pattern_r <= pattern_nxt;
      fade_r    <= fade_nxt;
      rising_r  <= rising_nxt;
      pwmcnt_r  <= pwmcnt_nxt;
    end
  end

  // event queue storage, contents undefined until written
  always_ff @(posedge clk) begin
    if (in_acc && fifo_wr_en) begin
      fifo_r[fifo_wr_idx] <= in_ch.button;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      leds_r     <= leds_nxt;
      mode_out_r <= mode_nxt;
      level_r    <= level_nxt;
      dropped_r  <= dropped_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.leds          = leds_r;
  assign out_ch.mode          = mode_out_r;
  assign out_ch.pwm_level     = level_r;
  assign out_ch.press_dropped = dropped_r;

endmodule
